// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("check failed");
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("check failed");
`endif

// ----- hw/rtl/mst_pkg.sv -----
// constants and types of the kruskal spanning tree block
`timescale 1ns / 1ps
`default_nettype none
package mst_pkg;
  localparam int MaxNodes   = 64;
  localparam int MaxEdges   = 1024;
  localparam int WeightBits = 16;
  localparam int NodeBits   = $clog2(MaxNodes);
  localparam int EdgeBits   = $clog2(MaxEdges);
  localparam int CountBits  = EdgeBits + 1;
  localparam int TotalBits  = 22;
  localparam int RankBits   = 7;
  localparam int NcBits     = 7;

  typedef struct packed {
    logic [NodeBits-1:0]          a;
    logic [NodeBits-1:0]          b;
    logic signed [WeightBits-1:0] w;
  } edge_t;

  localparam logic [TotalBits-1:0] TotMax = {1'b0, {(TotalBits-1){1'b1}}};
  localparam logic [TotalBits-1:0] TotMin = {1'b1, {(TotalBits-1){1'b0}}};
endpackage
`default_nettype wire

// ----- hw/rtl/minimum_spanning_tree_kruskal.sv -----
// top level: edge loading, merge sort over two memories, union-find sequencer
//
// channel   direction  handshake                 payload
// cfg       in         node_count_we_i           node_count_i
// edge      in         start_i && !busy_o        end_a_i end_b_i weight_i last_edge_i
// result    out        res_valid_o (one cycle)   kind_o .. last_result_o
//
// an edge without the last mark is taken while busy_o stays low
// the last edge starts a run: merge sort over ceil(log2(n)) passes, each merging
// word by word through IRD, IWAIT, MWAIT and MCMP, then copying back via COPY and COPYW
// then per edge ERD, EWAIT, EST, two root searches (FIND and FP, plus FWR per path-halving
// step) and UNION; one summary word ends each run; then the union-find tables are reset
// by a sweep over every node entry while busy_o stays high (the same sweep follows reset)
// the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none
module minimum_spanning_tree_kruskal import mst_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         node_count_we_i,
  input  wire logic [NcBits-1:0]            node_count_i,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [NodeBits-1:0]          end_a_i,
  input  wire logic [NodeBits-1:0]          end_b_i,
  input  wire logic signed [WeightBits-1:0] weight_i,
  input  wire logic                         last_edge_i,
  output logic                              res_valid_o,
  output logic                              kind_o,
  output logic [NodeBits-1:0]               low_end_o,
  output logic [NodeBits-1:0]               high_end_o,
  output logic signed [WeightBits-1:0]      edge_weight_o,
  output logic signed [TotalBits-1:0]       total_weight_o,
  output logic                              spanning_o,
  output logic                              overflow_o,
  output logic                              last_result_o
);
  localparam logic [4:0] S_IDLE = 5'd0, S_INIT = 5'd1, S_MRD = 5'd2, S_MCMP = 5'd3,
    S_MWR = 5'd4, S_COPY = 5'd5, S_COPYW = 5'd6, S_ERD = 5'd7, S_EWAIT = 5'd8,
    S_EST = 5'd9, S_FIND = 5'd10, S_FWR = 5'd11, S_UNION = 5'd12, S_SUM = 5'd13,
    S_CLR = 5'd14, S_IRD = 5'd15, S_IWAIT = 5'd16, S_MWAIT = 5'd17, S_FP = 5'd18;

  logic [4:0] state_q, state_d;
  logic [NcBits-1:0] nc_q;
  logic [CountBits-1:0] ecnt_q;
  logic ovf_q;
  logic [NodeBits-1:0] kept_q;
  logic signed [TotalBits-1:0] tot_q;

  // edge store and two index buffers
  edge_t mem_q [MaxEdges];
  logic [EdgeBits-1:0] ord_q [MaxEdges];
  logic [EdgeBits-1:0] tmp_q [MaxEdges];
  logic [NodeBits-1:0] par_q [MaxNodes];
  logic [RankBits-1:0] rank_q [MaxNodes];

  logic [CountBits-1:0] width_q, base_q, l_q, r_q, k_q, mid_q, hi_q;
  logic [EdgeBits-1:0] ordl_q, ordr_q;
  edge_t el_q, er_q, e_q;
  logic [NodeBits-1:0] c_q, ra_q;
  logic [NodeBits-1:0] p_q, gp_q;
  logic [RankBits-1:0] rka_q, rkb_q;
  logic side_q;

  logic [NcBits-1:0] n_eff;
  always_comb begin
    if (nc_q == '0) n_eff = NcBits'(1);
    else if (nc_q > NcBits'(MaxNodes)) n_eff = NcBits'(MaxNodes);
    else n_eff = nc_q;
  end

  logic accept;
  logic in_range;
  assign accept   = start_i && !busy_o;
  assign in_range = ({1'b0, end_a_i} < n_eff) && ({1'b0, end_b_i} < n_eff);
  assign busy_o   = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) nc_q <= NcBits'(1);
    else if (node_count_we_i) nc_q <= node_count_i;
  end

  // merge bookkeeping
  logic [CountBits-1:0] mid_c, hi_c, two_w;
  always_comb begin
    two_w = width_q << 1;
    mid_c = ((base_q + width_q) < ecnt_q) ? base_q + width_q : ecnt_q;
    hi_c  = ((base_q + two_w) < ecnt_q) ? base_q + two_w : ecnt_q;
  end

  logic take_l;
  assign take_l = (l_q < mid_q) && ((r_q >= hi_q) || (el_q.w <= er_q.w));

  logic [NodeBits-1:0] rb_c;
  assign rb_c = c_q;

  logic signed [TotalBits:0] sum_c;
  assign sum_c = {tot_q[TotalBits-1], tot_q} + (TotalBits+1)'(e_q.w);

  logic [CountBits-1:0] idx_q;
  logic [EdgeBits-1:0] rd_ord_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; ecnt_q <= '0; ovf_q <= 1'b0; kept_q <= '0; tot_q <= '0;
      res_valid_o <= 1'b0; idx_q <= '0; width_q <= '0; base_q <= '0;
      l_q <= '0; r_q <= '0; k_q <= '0; mid_q <= '0; hi_q <= '0;
      side_q <= 1'b0; c_q <= '0; ra_q <= '0;
    end else begin
      res_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_range) begin
              if (ecnt_q < CountBits'(MaxEdges)) begin
                mem_q[ecnt_q[EdgeBits-1:0]] <= '{end_a_i, end_b_i, weight_i};
                ord_q[ecnt_q[EdgeBits-1:0]] <= ecnt_q[EdgeBits-1:0];
                ecnt_q <= ecnt_q + 1'b1;
              end else ovf_q <= 1'b1;
            end
            if (last_edge_i) begin
              state_q <= S_INIT; width_q <= CountBits'(1);
            end
          end
        end
        S_INIT: begin
          if (width_q >= ecnt_q) begin
            idx_q <= '0; state_q <= S_ERD;
          end else begin
            // bounds of the first pair follow once base is cleared
            base_q <= '0; state_q <= S_MWR;
          end
        end
        S_MRD: begin
          // start of a run pair
          l_q <= base_q; r_q <= mid_q; k_q <= base_q;
          state_q <= S_IRD;
        end
        S_IRD: begin
          // fetch order entries at l and r
          ordl_q <= ord_q[l_q[EdgeBits-1:0]];
          ordr_q <= ord_q[r_q[EdgeBits-1:0]];
          state_q <= S_IWAIT;
        end
        S_IWAIT: begin
          el_q <= mem_q[ordl_q];
          state_q <= S_MWAIT;
        end
        S_MWAIT: begin
          er_q <= mem_q[ordr_q];
          state_q <= S_MCMP;
        end
        S_MCMP: begin
          if (k_q >= hi_q) begin
            if (hi_q >= ecnt_q) begin
              k_q <= '0; state_q <= S_COPY;
            end else begin
              base_q <= base_q + two_w;
              state_q <= S_MWR;
            end
          end else begin
            if (take_l) begin
              tmp_q[k_q[EdgeBits-1:0]] <= ordl_q; l_q <= l_q + 1'b1;
            end else begin
              tmp_q[k_q[EdgeBits-1:0]] <= ordr_q; r_q <= r_q + 1'b1;
            end
            k_q <= k_q + 1'b1;
            state_q <= S_IRD;
          end
        end
        S_MWR: begin
          mid_q <= mid_c; hi_q <= hi_c; state_q <= S_MRD;
        end
        S_COPY: begin
          if (k_q >= ecnt_q) begin
            width_q <= two_w; state_q <= S_INIT;
          end else begin
            rd_ord_q <= tmp_q[k_q[EdgeBits-1:0]]; state_q <= S_COPYW;
          end
        end
        S_COPYW: begin
          ord_q[k_q[EdgeBits-1:0]] <= rd_ord_q; k_q <= k_q + 1'b1; state_q <= S_COPY;
        end
        S_ERD: begin
          if (idx_q >= ecnt_q) state_q <= S_SUM;
          else begin
            rd_ord_q <= ord_q[idx_q[EdgeBits-1:0]]; state_q <= S_EWAIT;
          end
        end
        S_EWAIT: begin
          e_q <= mem_q[rd_ord_q]; state_q <= S_EST;
        end
        S_EST: begin
          c_q <= e_q.a; side_q <= 1'b0; state_q <= S_FIND;
        end
        S_FIND: begin
          // root walk: p = parent[c]
          p_q <= par_q[c_q]; state_q <= S_FP;
        end
        S_FP: begin
          if (c_q == p_q) begin
            if (!side_q) begin
              ra_q <= c_q; c_q <= e_q.b; side_q <= 1'b1; state_q <= S_FIND;
            end else begin
              rka_q <= rank_q[ra_q]; rkb_q <= rank_q[c_q]; state_q <= S_UNION;
            end
          end else begin
            gp_q <= par_q[p_q]; state_q <= S_FWR;
          end
        end
        S_FWR: begin
          // path halving: parent[c] = grandparent, then step to it
          par_q[c_q] <= gp_q; c_q <= gp_q; state_q <= S_FIND;
        end
        S_UNION: begin
          if (ra_q != rb_c) begin
            if (rka_q <= rkb_q) begin
              par_q[ra_q] <= rb_c; rank_q[rb_c] <= rkb_q + 1'b1;
            end else begin
              par_q[rb_c] <= ra_q; rank_q[ra_q] <= rka_q + 1'b1;
            end
            if (sum_c > (TotalBits+1)'(signed'(TotMax))) tot_q <= TotMax;
            else if (sum_c < (TotalBits+1)'(signed'(TotMin))) tot_q <= TotMin;
            else tot_q <= sum_c[TotalBits-1:0];
            if (kept_q != NodeBits'(MaxNodes-1)) begin
              res_valid_o <= 1'b1; kind_o <= 1'b0;
              low_end_o  <= (e_q.a < e_q.b) ? e_q.a : e_q.b;
              high_end_o <= (e_q.a < e_q.b) ? e_q.b : e_q.a;
              edge_weight_o <= e_q.w; total_weight_o <= '0;
              spanning_o <= 1'b0; overflow_o <= 1'b0; last_result_o <= 1'b0;
            end
            kept_q <= kept_q + 1'b1;
          end
          idx_q <= idx_q + 1'b1; state_q <= S_ERD;
        end
        S_SUM: begin
          res_valid_o <= 1'b1; kind_o <= 1'b1; low_end_o <= '0; high_end_o <= '0;
          edge_weight_o <= '0; total_weight_o <= tot_q;
          spanning_o <= (n_eff == NcBits'(1)) || ({1'b0, kept_q} == n_eff - 1'b1);
          overflow_o <= ovf_q; last_result_o <= 1'b1;
          ecnt_q <= '0; ovf_q <= 1'b0; kept_q <= '0; tot_q <= '0;
          c_q <= '0; state_q <= S_CLR;
        end
        S_CLR: begin
          par_q[c_q] <= c_q; rank_q[c_q] <= RankBits'(1);
          c_q <= c_q + 1'b1;
          if (c_q == NodeBits'(MaxNodes-1)) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mst_checker.sv -----
// port-level checker for the spanning tree block, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mst_checker import mst_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire logic                last_edge_i,
  input wire logic                res_valid_o,
  input wire logic                kind_o,
  input wire logic                last_result_o,
  input wire logic [NodeBits-1:0] low_end_o,
  input wire logic [NodeBits-1:0] high_end_o
);
  `CHK_IMPL(a_res_busy, clk_i, rst_ni, res_valid_o, busy_o)
  `CHK_IMPL(a_last_kind, clk_i, rst_ni, res_valid_o, kind_o == last_result_o)
  `CHK_IMPL(a_order, clk_i, rst_ni, res_valid_o && !kind_o, low_end_o <= high_end_o)
  `CHK_NEXT(a_run, clk_i, rst_ni, start_i && !busy_o && last_edge_i, busy_o)
  `CHK_NEXT(a_sum_end, clk_i, rst_ni, res_valid_o && last_result_o, !res_valid_o)
endmodule

bind minimum_spanning_tree_kruskal mst_checker u_chk (.*);
`default_nettype wire
